FILE: src/bcfd_pkg.sv
// Shared types, constants and keyword table for the brace counting frame delimiter.
`default_nettype none

package bcfd_pkg;

  localparam int unsigned BufferBytesDefault = 512;
  localparam int unsigned DepthBitsDefault   = 16;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned PosW     = 9;
  localparam int unsigned KeyW     = 4;

  localparam logic [KeyW-1:0]     KeyLen         = 4'd12;
  localparam logic [TimeoutW-1:0] TimeoutReset   = 16'd1000;
  localparam logic [ByteW-1:0]    OpenBrace      = 8'h7B;
  localparam logic [ByteW-1:0]    CloseBrace     = 8'h7D;
  localparam logic [ByteW-1:0]    NulByte        = 8'h00;

  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam logic        RegIdleTimeout = 1'b0;

  localparam int unsigned InTdataW  = 40;
  localparam int unsigned OutTdataW = 32;

  typedef struct packed {
    logic [PosW-1:0]  frame_length;
    logic             frame_has_keyword;
    logic             frame_done;
    logic             timeout_flush;
    logic [PosW-1:0]  byte_index;
    logic             byte_stored;
    logic [ByteW-1:0] out_byte;
  } result_t;

  function automatic logic [ByteW-1:0] key_char(input logic [KeyW-1:0] pos);
    logic [ByteW-1:0] c;
    case (pos)
      4'd0:    c = 8'h2B;
      4'd1:    c = 8'h4D;
      4'd2:    c = 8'h51;
      4'd3:    c = 8'h54;
      4'd4:    c = 8'h54;
      4'd5:    c = 8'h53;
      4'd6:    c = 8'h55;
      4'd7:    c = 8'h42;
      4'd8:    c = 8'h52;
      4'd9:    c = 8'h45;
      4'd10:   c = 8'h43;
      4'd11:   c = 8'h56;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: src/bcfd_apb_regs.sv
// APB configuration register holding the idle timeout.
`default_nettype none

module bcfd_apb_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bcfd_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [bcfd_pkg::ApbDataW-1:0]  pwdata,
  output logic      [bcfd_pkg::ApbDataW-1:0]  prdata,
  output logic                                pready,
  output logic      [bcfd_pkg::TimeoutW-1:0]  idle_timeout_o
);
  import bcfd_pkg::*;

  logic [TimeoutW-1:0] timeout_q, timeout_d;
  logic                wr_en;
  logic                sel_timeout;

  assign pready      = 1'b1;
  assign sel_timeout = (paddr[ApbAddrW-1] == RegIdleTimeout);
  assign wr_en       = psel && penable && pwrite && pready && sel_timeout;
  assign timeout_d   = wr_en ? pwdata[TimeoutW-1:0] : timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else begin
      timeout_q <= timeout_d;
    end
  end

  assign prdata = sel_timeout ? {{(ApbDataW-TimeoutW){1'b0}}, timeout_q} : '0;
  assign idle_timeout_o = timeout_q;

endmodule

`default_nettype wire

FILE: src/bcfd_frame_tracker.sv
// Frame state and per-byte update: timeout drop, fill count, keyword matcher, brace depth.
`default_nettype none

module bcfd_frame_tracker #(
  parameter int unsigned BUFFER_BYTES = bcfd_pkg::BufferBytesDefault,
  parameter int unsigned DEPTH_BITS   = bcfd_pkg::DepthBitsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          update_i,
  input  wire logic [bcfd_pkg::ByteW-1:0]    rx_byte_i,
  input  wire logic [bcfd_pkg::TimeW-1:0]    arrival_ms_i,
  input  wire logic [bcfd_pkg::TimeoutW-1:0] idle_timeout_i,
  output bcfd_pkg::result_t                  result_o
);
  import bcfd_pkg::*;

  localparam int unsigned FillW = $clog2(BUFFER_BYTES);
  localparam logic [FillW-1:0]      FillMax  = FillW'(BUFFER_BYTES - 1);
  localparam logic [DEPTH_BITS-1:0] DepthMax = {DEPTH_BITS{1'b1}};

  logic [FillW-1:0]      fill_q, fill_d;
  logic [DEPTH_BITS-1:0] depth_q, depth_d;
  logic [TimeW-1:0]      last_q, last_d;
  logic [KeyW-1:0]       kp_q, kp_d;
  logic                  ks_q, ks_d;
  logic                  zs_q, zs_d;

  logic [TimeW-1:0]      gap;
  logic                  flush;
  logic [FillW-1:0]      fill_a, fill_b;
  logic [DEPTH_BITS-1:0] depth_a, depth_b;
  logic [KeyW-1:0]       kp_a, kp_b;
  logic                  ks_a, ks_b, zs_a, zs_b;
  logic                  stored;
  logic                  done;
  logic [31:0]           index_ext, length_ext;

  always_comb begin
    gap   = arrival_ms_i - last_q;
    flush = (fill_q != '0) && (last_q != '0) && (gap > {16'd0, idle_timeout_i});

    fill_a  = flush ? '0 : fill_q;
    depth_a = flush ? '0 : depth_q;
    kp_a    = flush ? '0 : kp_q;
    ks_a    = flush ? 1'b0 : ks_q;
    zs_a    = flush ? 1'b0 : zs_q;

    stored = (fill_a < FillMax);
    fill_b = stored ? fill_a + 1'b1 : fill_a;
    kp_b   = kp_a;
    ks_b   = ks_a;
    zs_b   = zs_a;
    if (stored && !zs_a && !ks_a) begin
      if (rx_byte_i == NulByte) begin
        zs_b = 1'b1;
      end else if ((kp_a < KeyLen) && (rx_byte_i == key_char(kp_a))) begin
        if (kp_a == KeyLen - 1'b1) begin
          ks_b = 1'b1;
          kp_b = '0;
        end else begin
          kp_b = kp_a + 1'b1;
        end
      end else begin
        kp_b = (rx_byte_i == key_char('0)) ? KeyW'(1) : '0;
      end
    end

    depth_b = depth_a;
    done    = 1'b0;
    if (rx_byte_i == OpenBrace) begin
      if (depth_a != DepthMax) begin
        depth_b = depth_a + 1'b1;
      end
    end else if (rx_byte_i == CloseBrace) begin
      if (depth_a != '0) begin
        depth_b = depth_a - 1'b1;
      end
      done = (depth_b == '0) && (fill_b != '0);
    end

    index_ext  = stored ? 32'(fill_a) : 32'd0;
    length_ext = 32'(fill_b);

    result_o.out_byte          = rx_byte_i;
    result_o.byte_stored       = stored;
    result_o.byte_index        = index_ext[PosW-1:0];
    result_o.timeout_flush     = flush;
    result_o.frame_done        = done;
    result_o.frame_has_keyword = done && ks_b;
    result_o.frame_length      = length_ext[PosW-1:0];

    fill_d  = fill_q;
    depth_d = depth_q;
    last_d  = last_q;
    kp_d    = kp_q;
    ks_d    = ks_q;
    zs_d    = zs_q;
    if (update_i) begin
      fill_d  = done ? '0 : fill_b;
      depth_d = depth_b;
      last_d  = arrival_ms_i;
      kp_d    = done ? '0 : kp_b;
      ks_d    = done ? 1'b0 : ks_b;
      zs_d    = done ? 1'b0 : zs_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      depth_q <= '0;
      last_q  <= '0;
      kp_q    <= '0;
      ks_q    <= 1'b0;
      zs_q    <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      depth_q <= depth_d;
      last_q  <= last_d;
      kp_q    <= kp_d;
      ks_q    <= ks_d;
      zs_q    <= zs_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/brace_counting_frame_delimiter_unit.sv
// Top level of the brace counting frame delimiter: input stage, frame tracker, result stage.
//
//  channel   dir  handshake                transfer payload
//  s_axis    in   s_axis_tvalid/tready     tdata: rx_byte, arrival_ms
//  m_axis    out  m_axis_tvalid/tready     tdata: result fields, tlast: frame_done
//  apb       in   psel/penable/pready      idle_timeout_ms at address 0
//
// One byte per cycle sustained while m_axis is not stalled; each byte is held in the input
// register and then in the result register on its way from input transfer to result.
// The frame state updates as a byte leaves the input register, so the next byte
// sees it in the following cycle. A stalled result register holds the input stage.
// Reset clears the frame state and both stage valids; the timeout returns to 1000 ms.
`default_nettype none

module brace_counting_frame_delimiter_unit #(
  parameter int unsigned BUFFER_BYTES = bcfd_pkg::BufferBytesDefault,
  parameter int unsigned DEPTH_BITS   = bcfd_pkg::DepthBitsDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] rx_byte, [39:8] arrival_ms
  input  wire logic [bcfd_pkg::InTdataW-1:0]  s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [7:0] out_byte, [8] byte_stored, [17:9] byte_index, [18] timeout_flush,
  // [19] frame_has_keyword, [28:20] frame_length, [31:29] zero
  output logic      [bcfd_pkg::OutTdataW-1:0] m_axis_tdata,
  output logic                                m_axis_tlast,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bcfd_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [bcfd_pkg::ApbDataW-1:0]  pwdata,
  output logic      [bcfd_pkg::ApbDataW-1:0]  prdata,
  output logic                                pready
);
  import bcfd_pkg::*;

  logic                in_valid_q, in_valid_d;
  logic [ByteW-1:0]    in_byte_q, in_byte_d;
  logic [TimeW-1:0]    in_time_q, in_time_d;
  logic                out_valid_q, out_valid_d;
  result_t             out_res_q, out_res_d;
  result_t             res;
  logic [TimeoutW-1:0] idle_timeout;
  logic                advance;
  logic                fire;
  logic                in_xfer;

  bcfd_apb_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .idle_timeout_o (idle_timeout)
  );

  bcfd_frame_tracker #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .DEPTH_BITS   (DEPTH_BITS)
  ) u_tracker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .update_i       (fire),
    .rx_byte_i      (in_byte_q),
    .arrival_ms_i   (in_time_q),
    .idle_timeout_i (idle_timeout),
    .result_o       (res)
  );

  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d  = in_valid_q;
    in_byte_d   = in_byte_q;
    in_time_d   = in_time_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (fire) begin
      in_valid_d = 1'b0;
    end
    if (in_xfer) begin
      in_valid_d = 1'b1;
      in_byte_d  = s_axis_tdata[ByteW-1:0];
      in_time_d  = s_axis_tdata[ByteW+TimeW-1:ByteW];
    end
    if (advance) begin
      out_valid_d = fire;
      out_res_d   = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
    in_time_q <= in_time_d;
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_res_q.frame_done;
  assign m_axis_tdata  = {3'b000,
                          out_res_q.frame_length,
                          out_res_q.frame_has_keyword,
                          out_res_q.timeout_flush,
                          out_res_q.byte_index,
                          out_res_q.byte_stored,
                          out_res_q.out_byte};

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the brace counting frame delimiter unit.
module testbench;
  import bcfd_pkg::*;

  localparam int unsigned FillMax        = BufferBytesDefault - 1;
  localparam int unsigned WatchdogCycles = 1000;
  localparam int unsigned DrainCycles    = 4;
  localparam logic [ApbAddrW-1:0] TimeoutAddr = ApbAddrW'(4 * int'(RegIdleTimeout));
  localparam logic [ApbAddrW-1:0] SpareAddr   = ApbAddrW'(4 * (int'(RegIdleTimeout) + 1));
  localparam logic [8*int'(KeyLen)-1:0] Keyword = "+MQTTSUBRECV";

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             stored;
    logic [PosW-1:0]  index;
    logic             flushed;
    logic             done;
    logic             keyword;
    logic [PosW-1:0]  length;
  } frame_result_t;

  typedef struct packed {
    logic [ByteW-1:0] rx;
    logic [TimeW-1:0] at;
    logic             pinned;
    frame_result_t    res;
  } stim_row_t;

  localparam stim_row_t Directed [25] = '{
    '{OpenBrace, 32'd0, 1'b1, '{OpenBrace, 1'b1, 9'd0, 1'b0, 1'b0, 1'b0, 9'd1}},
    '{"+", 32'd1, 1'b0, '0},
    '{"M", 32'd2, 1'b0, '0},
    '{"Q", 32'd3, 1'b0, '0},
    '{"T", 32'd4, 1'b0, '0},
    '{"T", 32'd5, 1'b0, '0},
    '{"S", 32'd6, 1'b0, '0},
    '{"U", 32'd7, 1'b0, '0},
    '{"B", 32'd8, 1'b0, '0},
    '{"R", 32'd9, 1'b0, '0},
    '{"E", 32'd10, 1'b0, '0},
    '{"C", 32'd11, 1'b0, '0},
    '{"V", 32'd12, 1'b0, '0},
    '{CloseBrace, 32'd13, 1'b1, '{CloseBrace, 1'b1, 9'd13, 1'b0, 1'b1, 1'b1, 9'd14}},
    '{CloseBrace, 32'd14, 1'b1, '{CloseBrace, 1'b1, 9'd0, 1'b0, 1'b1, 1'b0, 9'd1}},
    '{NulByte, 32'd15, 1'b0, '0},
    '{"+", 32'd16, 1'b0, '0},
    '{8'hFF, 32'd5000, 1'b1, '{8'hFF, 1'b1, 9'd0, 1'b1, 1'b0, 1'b0, 9'd1}},
    '{OpenBrace, 32'hFFFF_FFF0, 1'b0, '0},
    '{OpenBrace, 32'd5, 1'b0, '0},
    '{CloseBrace, 32'd6, 1'b0, '0},
    '{CloseBrace, 32'hFFFF_FFFF, 1'b0, '0},
    '{"a", 32'd0, 1'b0, '0},
    '{"b", 32'd60000, 1'b0, '0},
    '{CloseBrace, 32'd60001, 1'b0, '0}
  };

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [ApbAddrW-1:0]  paddr         = '0;
  logic [ApbDataW-1:0]  pwdata        = '0;
  logic [ApbDataW-1:0]  prdata;
  logic                 pready;

  logic [TimeoutW-1:0]        idle_limit_ms = TimeoutReset;
  logic [9:0]                 frame_fill    = '0;
  logic [DepthBitsDefault-1:0] nest_depth   = '0;
  logic [TimeW-1:0]           prev_arrival  = '0;
  logic [KeyW-1:0]            key_pos       = '0;
  logic                       key_found     = 1'b0;
  logic                       nul_found     = 1'b0;

  frame_result_t    pending_results [$];
  logic [TimeW-1:0] now_ms       = '0;
  int unsigned      mismatches   = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      gap_pct      = 0;
  int unsigned      stall_pct    = 0;
  int unsigned      sent_items   = 0;

  brace_counting_frame_delimiter_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [ByteW-1:0] key_byte(input int unsigned pos);
    return Keyword[8*(int'(KeyLen) - 1 - int'(pos)) +: 8];
  endfunction

  function automatic void drop_frame();
    frame_fill = '0;
    key_pos    = '0;
    key_found  = 1'b0;
    nul_found  = 1'b0;
  endfunction

  function automatic frame_result_t track_byte(input logic [ByteW-1:0] b,
                                               input logic [TimeW-1:0] at);
    frame_result_t    r;
    logic [TimeW-1:0] gap;
    r      = '0;
    r.data = b;
    gap    = at - prev_arrival;
    if (frame_fill != 0 && prev_arrival != 0 && gap > TimeW'(idle_limit_ms)) begin
      drop_frame();
      nest_depth = '0;
      r.flushed  = 1'b1;
    end
    if (frame_fill < FillMax) begin
      r.index    = frame_fill[PosW-1:0];
      frame_fill = frame_fill + 1'b1;
      r.stored   = 1'b1;
      if (!nul_found && !key_found) begin
        if (b == NulByte) begin
          nul_found = 1'b1;
        end else if (b == key_byte(key_pos)) begin
          key_pos = key_pos + 1'b1;
          if (key_pos == KeyLen) begin
            key_found = 1'b1;
            key_pos   = '0;
          end
        end else begin
          key_pos = (b == key_byte(0)) ? KeyW'(1) : KeyW'(0);
        end
      end
    end
    r.length = frame_fill[PosW-1:0];
    if (b == OpenBrace) begin
      if (nest_depth != '1) nest_depth = nest_depth + 1'b1;
    end else if (b == CloseBrace) begin
      if (nest_depth != 0) nest_depth = nest_depth - 1'b1;
      if (nest_depth == 0 && frame_fill != 0) begin
        r.done    = 1'b1;
        r.keyword = key_found;
        drop_frame();
      end
    end
    prev_arrival = at;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b, input logic [TimeW-1:0] at,
                           input logic pinned = 1'b0, input frame_result_t fixed = '0);
    frame_result_t r;
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {at, b};
    do @(posedge clk_i); while (!s_axis_tready);
    r = track_byte(b, at);
    pending_results.push_back(pinned ? fixed : r);
  endtask

  task automatic emit(input logic [ByteW-1:0] b);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 1) now_ms = $urandom();
    else if (roll < 3) now_ms = now_ms + TimeW'(idle_limit_ms) + 1 + $urandom_range(50);
    else if (roll < 4) now_ms = '0;
    else if (roll >= 14) now_ms = now_ms + $urandom_range(1, 40);
    send_byte(b, now_ms);
    sent_items++;
  endtask

  task automatic send_frame();
    int unsigned kind;
    int unsigned pick;
    int unsigned nest;
    kind = $urandom_range(99);
    nest = 0;
    if (kind < 15) begin
      repeat ($urandom_range(1, 8)) emit(8'($urandom()));
    end else begin
      emit(OpenBrace);
      repeat ($urandom_range(0, 30)) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          if (pick < 3) for (int i = 0; i < $urandom_range(1, 11); i++) emit(key_byte(i));
          for (int i = 0; i < int'(KeyLen); i++) emit(key_byte(i));
        end else if (pick < 18) begin
          emit(OpenBrace);
          nest++;
        end else if (pick < 28 && nest > 0) begin
          emit(CloseBrace);
          nest--;
        end else if (pick < 31) begin
          emit(NulByte);
        end else if (pick < 34) begin
          emit(8'($urandom()));
        end else begin
          emit(8'($urandom_range(32, 122)));
        end
      end
      // leave some frames open
      if (kind < 92) repeat (nest + 1) emit(CloseBrace);
    end
  endtask

  task automatic run_random(input int unsigned count);
    sent_items = 0;
    while (sent_items < count) send_frame();
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic reg_access(input logic wr, input logic [ApbAddrW-1:0] addr,
                            input logic [ApbDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (!wr && prdata[TimeoutW-1:0] != idle_limit_ms)
      report_mismatch("idle_timeout_ms readback", prdata, idle_limit_ms);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_timeout(input logic [TimeoutW-1:0] value);
    reg_access(1'b1, TimeoutAddr, {16'($urandom()), value});
    idle_limit_ms = value;
    reg_access(1'b1, SpareAddr, $urandom());
    reg_access(1'b0, TimeoutAddr, '0);
  endtask

  always @(posedge clk_i) begin
    frame_result_t got;
    frame_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tdata[17:9], m_axis_tdata[18],
              m_axis_tlast, m_axis_tdata[19], m_axis_tdata[28:20]};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer", got.data, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.data != want.data) report_mismatch("out_byte", got.data, want.data);
        if (got.stored != want.stored)
          report_mismatch("byte_stored", got.stored, want.stored);
        if (got.index != want.index) report_mismatch("byte_index", got.index, want.index);
        if (got.flushed != want.flushed)
          report_mismatch("timeout_flush", got.flushed, want.flushed);
        if (got.done != want.done) report_mismatch("frame_done", got.done, want.done);
        if (got.keyword != want.keyword)
          report_mismatch("frame_has_keyword", got.keyword, want.keyword);
        if (got.length != want.length)
          report_mismatch("frame_length", got.length, want.length);
      end
    end
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogCycles) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (Directed[i])
      send_byte(Directed[i].rx, Directed[i].at, Directed[i].pinned, Directed[i].res);
    drain();

    set_timeout('1);
    now_ms = 32'd100;
    run_random(250);
    // overfill the frame, then flush on idle
    now_ms = 32'h1000_0000;
    repeat (FillMax + 8) send_byte(OpenBrace, now_ms);
    repeat (3) send_byte(CloseBrace, now_ms);
    now_ms = now_ms + TimeW'(idle_limit_ms) + 5;
    send_byte(CloseBrace, now_ms);
    drain();

    gap_pct = 69;
    set_timeout('0);
    run_random(250);
    drain();

    gap_pct   = 0;
    stall_pct = 69;
    set_timeout(TimeoutW'($urandom_range(1, 3000)));
    run_random(250);
    drain();

    gap_pct   = 15;
    stall_pct = 15;
    set_timeout(TimeoutReset);
    run_random(250);
    drain();

    if (pending_results.size() != 0)
      report_mismatch("results never delivered", pending_results.size(), 0);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
